FILE: sv/rmmcs_pkg.sv
// Shared constants and types for the RGB min/max contrast stretch block.
`default_nettype none

package rmmcs_pkg;

  // Default channel width and the reset value of the stretch target.
  localparam int CHANNEL_BITS_DEF = 8;
  localparam int MAX_VALUE_RESET  = 255;

  // One lane per color channel.
  localparam int NUM_LANES  = 3;
  localparam int LANE_RED   = 0;
  localparam int LANE_GREEN = 1;
  localparam int LANE_BLUE  = 2;

  // Control that the top level hands to every lane.
  typedef struct packed {
    logic accept;
    logic func;
    logic start_of_image;
    logic take;
  } lane_ctl_t;

  // Status that each lane reports to the top level and the merge stage.
  typedef struct packed {
    logic idle;
    logic done;
  } lane_sts_t;

endpackage

`default_nettype wire

FILE: sv/rmmcs_lane.sv
// One color lane: running min/max tracking and the iterative stretch divider.
`default_nettype none

module rmmcs_lane
  import rmmcs_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire lane_ctl_t               ctl,
  input  wire logic [CHANNEL_BITS-1:0] max_value,
  input  wire logic [CHANNEL_BITS-1:0] chan_in,
  output lane_sts_t                    sts,
  output logic      [CHANNEL_BITS-1:0] res
);

  localparam int B  = CHANNEL_BITS;
  localparam int CW = (B > 1) ? $clog2(B) : 1;

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_MULT = 4'b0010,
    L_DIV  = 4'b0100,
    L_DONE = 4'b1000
  } lane_state_t;

  lane_state_t   state_r, state_nxt;
  logic [B-1:0]  lo_r, lo_nxt;
  logic [B-1:0]  hi_r, hi_nxt;
  logic [B-1:0]  n_r, n_nxt;
  logic [B-1:0]  d_r, d_nxt;
  logic [B:0]    rem_r, rem_nxt;
  logic [B-1:0]  qs_r, qs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [B-1:0]  res_r, res_nxt;

  // Classification of a stretch item against the measured range.
  logic          hi_lt_lo;
  logic [B:0]    n_diff;
  logic [B-1:0]  d_diff;
  logic [B-1:0]  pass_val;

  // Measure pass: optionally reloaded bounds, then the new value folded in.
  logic [B-1:0]  lo_base;
  logic [B-1:0]  hi_base;

  // Multiply and divide datapath.
  logic [2*B-1:0] prod;
  logic [2*B:0]   num;
  logic [B+1:0]   trial;
  logic [B+1:0]   den;
  logic [B+1:0]   diff;
  logic           ge;
  logic [B:0]     qs_wide;

  always_comb begin
    hi_lt_lo = hi_r < lo_r;
    if (hi_lt_lo) begin
      n_diff = {1'b0, lo_r} - {1'b0, chan_in};
      d_diff = lo_r - hi_r;
    end else begin
      n_diff = {1'b0, chan_in} - {1'b0, lo_r};
      d_diff = hi_r - lo_r;
    end
    pass_val = (chan_in > max_value) ? max_value : chan_in;
    lo_base  = ctl.start_of_image ? max_value : lo_r;
    hi_base  = ctl.start_of_image ? '0 : hi_r;
  end

  always_comb begin
    prod    = n_r * max_value;
    num     = {prod, 1'b0} + (2*B+1)'(d_r);
    trial   = {rem_r, qs_r[B-1]};
    den     = {1'b0, d_r, 1'b0};
    diff    = trial - den;
    ge      = trial >= den;
    qs_wide = {qs_r, ge};
  end

  // Lane sequencer: accept, multiply, one quotient bit per cycle; early results go to done.
  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    n_nxt     = n_r;
    d_nxt     = d_r;
    rem_nxt   = rem_r;
    qs_nxt    = qs_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    unique case (state_r)
      L_IDLE: begin
        if (ctl.accept && !ctl.func) begin
          lo_nxt = (chan_in < lo_base) ? chan_in : lo_base;
          hi_nxt = (chan_in > hi_base) ? chan_in : hi_base;
        end else if (ctl.accept) begin
          n_nxt = n_diff[B-1:0];
          d_nxt = d_diff;
          priority if (lo_r == hi_r) begin
            // Flat channel: the value passes through, clamped.
            res_nxt   = pass_val;
            state_nxt = L_DONE;
          end else if (n_diff[B]) begin
            // Below the range: the quotient is negative or zero.
            res_nxt   = '0;
            state_nxt = L_DONE;
          end else if (n_diff[B-1:0] > d_diff) begin
            // Above the range: the quotient reaches at least the target.
            res_nxt   = max_value;
            state_nxt = L_DONE;
          end else begin
            state_nxt = L_MULT;
          end
        end
      end
      L_MULT: begin
        rem_nxt   = num[2*B:B];
        qs_nxt    = num[B-1:0];
        cnt_nxt   = CW'(B - 1);
        state_nxt = L_DIV;
      end
      L_DIV: begin
        rem_nxt = ge ? diff[B:0] : trial[B:0];
        qs_nxt  = qs_wide[B-1:0];
        if (cnt_r == '0) begin
          res_nxt   = qs_wide[B-1:0];
          state_nxt = L_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      L_DONE: begin
        if (ctl.take) begin
          state_nxt = L_IDLE;
        end
      end
      default: begin
        state_nxt = L_IDLE;
      end
    endcase
  end

  // Control state and the measured bounds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      lo_r    <= B'(MAX_VALUE_RESET);
      hi_r    <= '0;
    end else begin
      state_r <= state_nxt;
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    qs_r  <= qs_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
  end

  assign sts.idle = (state_r == L_IDLE);
  assign sts.done = (state_r == L_DONE);
  assign res      = res_r;

  // A new item only reaches a lane that has finished its previous one.
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.accept |-> (state_r == L_IDLE))
    else $error("lane accepted an item while busy");

  // The partial remainder always stays below the divisor.
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == L_DIV) |-> (rem_r < {d_r, 1'b0}))
    else $error("divider remainder out of range");

  // A result taken by the merge stage frees the lane.
  a_take_release: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == L_DONE) && ctl.take) |=> (state_r == L_IDLE))
    else $error("lane did not release after its result was taken");

endmodule

`default_nettype wire

FILE: sv/rmmcs_merge.sv
// Merge stage: joins the lane results into one output item register.
`default_nettype none

module rmmcs_merge
  import rmmcs_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire lane_sts_t               sts      [NUM_LANES],
  input  wire logic [CHANNEL_BITS-1:0] lane_res [NUM_LANES],
  input  wire logic                    out_ready,
  output logic                         out_valid,
  output logic      [CHANNEL_BITS-1:0] out_data [NUM_LANES],
  output logic                         take
);

  logic                    all_done;
  logic                    valid_r, valid_nxt;
  logic [CHANNEL_BITS-1:0] data_r [NUM_LANES];

  // The item is complete once every lane has its channel ready.
  always_comb begin
    all_done = 1'b1;
    for (int i = 0; i < NUM_LANES; i++) begin
      all_done = all_done & sts[i].done;
    end
  end

  // Load when the output register is empty or being drained this cycle.
  assign take = all_done && (!valid_r || out_ready);

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        data_r[i] <= lane_res[i];
      end
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

FILE: sv/rgb_min_max_contrast_stretch_top.sv
// Top level of the RGB min/max contrast stretch block.
//
//   channel  direction  handshake                 payload
//   in_      input      in_valid / in_ready       func, start_of_image, red/green/blue_in
//   out_     output     out_valid / out_ready     red/green/blue_out
//   cfg_     input      cfg_we (no wait)          cfg_wdata = max_value
//
// A measure item (func 0) updates the bounds as it is taken. A stretch item holds
// the lanes through accept, a multiply state and the bit-serial divider in each
// lane, then the merge; flat, below- or above-range channels skip the multiply
// and divider and wait in the done state until the merge takes the result.
// Reset is synchronous and active low; bounds and max_value return to their
// reset values. A stalled output holds its item while the lanes take the next.
`default_nettype none

module rgb_min_max_contrast_stretch_top
  import rmmcs_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    in_func,
  input  wire logic                    in_start_of_image,
  input  wire logic [CHANNEL_BITS-1:0] in_red_in,
  input  wire logic [CHANNEL_BITS-1:0] in_green_in,
  input  wire logic [CHANNEL_BITS-1:0] in_blue_in,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic      [CHANNEL_BITS-1:0] out_red_out,
  output logic      [CHANNEL_BITS-1:0] out_green_out,
  output logic      [CHANNEL_BITS-1:0] out_blue_out,
  input  wire logic                    cfg_we,
  input  wire logic [CHANNEL_BITS-1:0] cfg_wdata
);

  logic [CHANNEL_BITS-1:0] max_value_r, max_value_nxt;
  logic [CHANNEL_BITS-1:0] chan_in  [NUM_LANES];
  logic [CHANNEL_BITS-1:0] lane_res [NUM_LANES];
  logic [CHANNEL_BITS-1:0] out_data [NUM_LANES];
  lane_sts_t               lane_sts [NUM_LANES];
  lane_ctl_t               ctl;
  logic                    take;
  logic                    all_idle;

  // Configuration register.
  assign max_value_nxt = cfg_we ? cfg_wdata : max_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_value_r <= CHANNEL_BITS'(MAX_VALUE_RESET);
    end else begin
      max_value_r <= max_value_nxt;
    end
  end

  // Input is taken only when every lane is free.
  always_comb begin
    all_idle = 1'b1;
    for (int i = 0; i < NUM_LANES; i++) begin
      all_idle = all_idle & lane_sts[i].idle;
    end
  end

  assign in_ready           = all_idle;
  assign ctl.accept         = in_valid && all_idle;
  assign ctl.func           = in_func;
  assign ctl.start_of_image = in_start_of_image;
  assign ctl.take           = take;

  assign chan_in[LANE_RED]   = in_red_in;
  assign chan_in[LANE_GREEN] = in_green_in;
  assign chan_in[LANE_BLUE]  = in_blue_in;

  // One lane per color channel.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    rmmcs_lane #(
      .CHANNEL_BITS(CHANNEL_BITS)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .max_value(max_value_r),
      .chan_in  (chan_in[g]),
      .sts      (lane_sts[g]),
      .res      (lane_res[g])
    );
  end

  // Merge the lane results into the output item.
  rmmcs_merge #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .sts      (lane_sts),
    .lane_res (lane_res),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data (out_data),
    .take     (take)
  );

  assign out_red_out   = out_data[LANE_RED];
  assign out_green_out = out_data[LANE_GREEN];
  assign out_blue_out  = out_data[LANE_BLUE];

endmodule

`default_nettype wire

FILE: dv/stretch_monitor.sv
// Watches the contrast stretch channels, predicts each stretched pixel and compares it.
`timescale 1ns / 1ps

module stretch_monitor
  import rmmcs_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        in_func,
  input  logic                        in_start_of_image,
  input  logic [CHANNEL_BITS_DEF-1:0] in_red_in,
  input  logic [CHANNEL_BITS_DEF-1:0] in_green_in,
  input  logic [CHANNEL_BITS_DEF-1:0] in_blue_in,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [CHANNEL_BITS_DEF-1:0] out_red_out,
  input  logic [CHANNEL_BITS_DEF-1:0] out_green_out,
  input  logic [CHANNEL_BITS_DEF-1:0] out_blue_out,
  input  logic                        cfg_we,
  input  logic [CHANNEL_BITS_DEF-1:0] cfg_wdata,
  output int                          failures,
  output int                          pending
);

  localparam int CB = CHANNEL_BITS_DEF;

  typedef struct packed {
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
  } rgb_pixel_t;

  // Tracked copy of the stretch target and the per-channel bounds.
  logic [CB-1:0] target_max;
  logic [CB-1:0] red_lo, red_hi, green_lo, green_hi, blue_lo, blue_hi;

  rgb_pixel_t stretched_pixels[$];
  int         error_count;

  initial begin
    error_count = 0;
  end

  // Maps one channel value onto 0..top_val with the measured bounds, rounding half up.
  function automatic logic [CB-1:0] stretch_channel(input logic [CB-1:0] v,
                                                    input logic [CB-1:0] lo,
                                                    input logic [CB-1:0] hi,
                                                    input logic [CB-1:0] top_val);
    int vi, li, hi_i, m, n, d, num, den, q;
    vi   = int'(v);
    li   = int'(lo);
    hi_i = int'(hi);
    m    = int'(top_val);
    if (lo == hi) begin
      q = vi;
    end else begin
      n = vi - li;
      d = hi_i - li;
      if (d < 0) begin
        n = -n;
        d = -d;
      end
      num = 2 * n * m + d;
      den = 2 * d;
      q   = num / den;
      // Division truncates toward zero; pull negative quotients down to the floor.
      if ((num % den) != 0 && num < 0) begin
        q = q - 1;
      end
    end
    if (q < 0) begin
      q = 0;
    end
    if (q > m) begin
      q = m;
    end
    return q[CB-1:0];
  endfunction

  always @(posedge clk) begin
    rgb_pixel_t want;
    if (!rst_n) begin
      target_max = CB'(MAX_VALUE_RESET);
      red_lo     = CB'(MAX_VALUE_RESET);
      green_lo   = CB'(MAX_VALUE_RESET);
      blue_lo    = CB'(MAX_VALUE_RESET);
      red_hi     = '0;
      green_hi   = '0;
      blue_hi    = '0;
      stretched_pixels.delete();
    end else begin
      if (cfg_we) begin
        target_max = cfg_wdata;
      end

      // Compare a delivered pixel against the oldest prediction.
      if (out_valid && out_ready) begin
        if (stretched_pixels.size() == 0) begin
          $error("unexpected output item: red %0d green %0d blue %0d",
                 out_red_out, out_green_out, out_blue_out);
          error_count++;
        end else begin
          want = stretched_pixels.pop_front();
          if (out_red_out !== want.red) begin
            $error("red_out: expected %0d, actual %0d", want.red, out_red_out);
            error_count++;
          end
          if (out_green_out !== want.green) begin
            $error("green_out: expected %0d, actual %0d", want.green, out_green_out);
            error_count++;
          end
          if (out_blue_out !== want.blue) begin
            $error("blue_out: expected %0d, actual %0d", want.blue, out_blue_out);
            error_count++;
          end
        end
      end

      // A measure item widens the bounds; a stretch item yields one predicted pixel.
      if (in_valid && in_ready) begin
        if (!in_func) begin
          if (in_start_of_image) begin
            red_lo   = target_max;
            green_lo = target_max;
            blue_lo  = target_max;
            red_hi   = '0;
            green_hi = '0;
            blue_hi  = '0;
          end
          if (in_red_in < red_lo) red_lo = in_red_in;
          if (in_red_in > red_hi) red_hi = in_red_in;
          if (in_green_in < green_lo) green_lo = in_green_in;
          if (in_green_in > green_hi) green_hi = in_green_in;
          if (in_blue_in < blue_lo) blue_lo = in_blue_in;
          if (in_blue_in > blue_hi) blue_hi = in_blue_in;
        end else begin
          want.red   = stretch_channel(in_red_in, red_lo, red_hi, target_max);
          want.green = stretch_channel(in_green_in, green_lo, green_hi, target_max);
          want.blue  = stretch_channel(in_blue_in, blue_lo, blue_hi, target_max);
          stretched_pixels.push_back(want);
        end
      end
    end
    pending  <= stretched_pixels.size();
    failures <= error_count;
  end

endmodule

FILE: dv/testbench.sv
// Stimulus and verdict for the RGB min/max contrast stretch block.
`timescale 1ns / 1ps

module testbench;
  import rmmcs_pkg::*;

  localparam int CB           = CHANNEL_BITS_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_TIME  = 2 * (CB + 3) + 8;
  localparam int RANDOM_ITEMS = 1750;
  localparam int MAX_FRAME    = 12;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic          in_func = 1'b0;
  logic          in_start_of_image = 1'b0;
  logic [CB-1:0] in_red_in = '0;
  logic [CB-1:0] in_green_in = '0;
  logic [CB-1:0] in_blue_in = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [CB-1:0] out_red_out, out_green_out, out_blue_out;
  logic          cfg_we = 1'b0;
  logic [CB-1:0] cfg_wdata = '0;

  int failures, pending;
  int in_gap_max = 9;
  int out_gap_max = 9;
  int sent_items = 0;
  int stretch_items = 0;
  int settings_used = 0;
  int frames_sent = 0;
  int cycles = 0;

  rgb_min_max_contrast_stretch_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_start_of_image (in_start_of_image),
    .in_red_in         (in_red_in),
    .in_green_in       (in_green_in),
    .in_blue_in        (in_blue_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_red_out       (out_red_out),
    .out_green_out     (out_green_out),
    .out_blue_out      (out_blue_out),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  stretch_monitor monitor (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_start_of_image (in_start_of_image),
    .in_red_in         (in_red_in),
    .in_green_in       (in_green_in),
    .in_blue_in        (in_blue_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_red_out       (out_red_out),
    .out_green_out     (out_green_out),
    .out_blue_out      (out_blue_out),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .failures          (failures),
    .pending           (pending)
  );

  always #6 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: stall a random number of cycles before taking each item.
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = $urandom_range(0, out_gap_max);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Offers one pixel after a random gap and holds it until it is taken.
  task automatic send_pixel(input logic f, input logic sop, input logic [CB-1:0] r,
                            input logic [CB-1:0] g, input logic [CB-1:0] b);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_func           <= f;
    in_start_of_image <= sop;
    in_red_in         <= r;
    in_green_in       <= g;
    in_blue_in        <= b;
    in_valid          <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    sent_items++;
    if (f) stretch_items++;
  endtask

  // Stops sending, waits for every predicted pixel, then lets the lanes go quiet.
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_TIME) @(posedge clk);
  endtask

  // Writes the stretch target while nothing is in flight.
  task automatic program_max(input logic [CB-1:0] value);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  // Draws a channel value from base..base+span, kept inside the channel range.
  function automatic logic [CB-1:0] pick_value(input int base, input int span);
    int v;
    v = base + $urandom_range(0, span);
    if (v > 255) v = 255;
    return v[CB-1:0];
  endfunction

  initial begin
    logic [CB-1:0] frame_r[MAX_FRAME], frame_g[MAX_FRAME], frame_b[MAX_FRAME];
    logic [CB-1:0] max_choices[8];
    int base[3], span[3];
    int n, kind, goal, next_switch;

    max_choices = '{8'd255, 8'd1, 8'd128, 8'd254, 8'd2, 8'd0, 8'd77, 8'd255};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: stretch straight after reset, with and without the start flag.
    send_pixel(1'b1, 1'b0, 8'd0, 8'd128, 8'd255);
    send_pixel(1'b1, 1'b1, 8'd255, 8'd0, 8'd37);
    // Red spans 10..200, green stays flat at 0, blue covers the full range.
    send_pixel(1'b0, 1'b1, 8'd10, 8'd0, 8'd0);
    send_pixel(1'b0, 1'b0, 8'd200, 8'd0, 8'd255);
    send_pixel(1'b0, 1'b0, 8'd90, 8'd0, 8'd17);
    send_pixel(1'b1, 1'b0, 8'd0, 8'd0, 8'd0);
    send_pixel(1'b1, 1'b0, 8'd255, 8'd255, 8'd255);
    send_pixel(1'b1, 1'b0, 8'd10, 8'd0, 8'd128);
    send_pixel(1'b1, 1'b0, 8'd105, 8'd0, 8'd1);
    send_pixel(1'b1, 1'b0, 8'd200, 8'd0, 8'd254);
    send_pixel(1'b1, 1'b1, 8'd107, 8'd0, 8'd127);
    // A zero target forces every stretched channel to zero.
    program_max(8'd0);
    send_pixel(1'b1, 1'b0, 8'd50, 8'd50, 8'd50);
    send_pixel(1'b0, 1'b1, 8'd3, 8'd200, 8'd7);
    send_pixel(1'b1, 1'b0, 8'd3, 8'd200, 8'd255);
    // Measured values above the target still enter the bounds.
    program_max(8'd100);
    send_pixel(1'b0, 1'b1, 8'd200, 8'd150, 8'd255);
    send_pixel(1'b0, 1'b0, 8'd50, 8'd101, 8'd255);
    send_pixel(1'b1, 1'b0, 8'd255, 8'd0, 8'd120);
    send_pixel(1'b1, 1'b0, 8'd125, 8'd101, 8'd200);
    send_pixel(1'b1, 1'b0, 8'd50, 8'd150, 8'd0);

    // Random frames under a sequence of targets and idling styles.
    goal        = sent_items + RANDOM_ITEMS;
    next_switch = sent_items;
    while (sent_items < goal) begin
      if (sent_items >= next_switch) begin
        if (settings_used % 8 == 6) begin
          program_max(CB'($urandom_range(1, 255)));
        end else begin
          program_max(max_choices[settings_used % 8]);
        end
        in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 9;
        out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
        next_switch = sent_items + 200;
      end

      kind = $urandom_range(0, 9);
      n    = $urandom_range(1, MAX_FRAME);
      // Per channel either the full range or a narrow band, flat ones included.
      for (int c = 0; c < 3; c++) begin
        span[c] = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 255;
        base[c] = (span[c] == 255) ? 0 : $urandom_range(0, 255);
      end
      for (int i = 0; i < n; i++) begin
        frame_r[i] = pick_value(base[0], span[0]);
        frame_g[i] = pick_value(base[1], span[1]);
        frame_b[i] = pick_value(base[2], span[2]);
      end

      if (kind == 0) begin
        // Noise: any function and flag, any values.
        for (int i = 0; i < n; i++) begin
          send_pixel(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     CB'($urandom_range(0, 255)), CB'($urandom_range(0, 255)),
                     CB'($urandom_range(0, 255)));
        end
      end else begin
        // Measure pass; a broken frame skips it or continues the previous bounds.
        if (kind != 1) begin
          for (int i = 0; i < n; i++) begin
            send_pixel(1'b0, (i == 0) && (kind != 2), frame_r[i], frame_g[i], frame_b[i]);
          end
        end
        // Stretch pass over the same pixels, now and then one from outside the range.
        for (int i = 0; i < n; i++) begin
          send_pixel(1'b1, $urandom_range(0, 7) == 0, frame_r[i], frame_g[i], frame_b[i]);
        end
        if ($urandom_range(0, 3) == 0) begin
          send_pixel(1'b1, 1'b0, CB'($urandom_range(0, 255)), CB'($urandom_range(0, 255)),
                     CB'($urandom_range(0, 255)));
        end
      end
      frames_sent++;
    end

    drain_block();
    $display("Covered %0d pixels (%0d stretched) in %0d frames under %0d target settings.",
             sent_items, stretch_items, frames_sent, settings_used);
    $display("Idling on both channels varied between none and up to nine cycles per item.");
    if (failures == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
